/* design/nsl_pkg.sv */
// ----------------------------------------------------------------------------
// nsl_pkg
// Shared constants, codes and pipeline types for the nearest site labeler.
// ----------------------------------------------------------------------------
package nsl_pkg;

    localparam int MAX_SITES  = 64;
    localparam int COORD_BITS = 10;

    localparam int XY_W      = 10;
    localparam int IDX_W     = 6;
    localparam int LABEL_W   = 4;
    localparam int NUM_W     = 7;
    localparam int DIST_W    = 21;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    localparam int SLOT_W  = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int ACT_RAW = $clog2(MAX_SITES + 1);
    localparam int ACT_W   = (NUM_W > ACT_RAW) ? NUM_W : ACT_RAW;
    localparam int CMP_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int SQ_W    = 2 * COORD_BITS + 1;
    localparam int DW      = (SQ_W > DIST_W) ? SQ_W : DIST_W;

    localparam logic [DW-1:0] DIST_MAX = DW'((64'd1 << DIST_W) - 64'd1);

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } nsl_cmd_t;

    typedef enum logic
    {
        METRIC_EUCLID    = 1'b0,
        METRIC_MANHATTAN = 1'b1
    } nsl_metric_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_NUM_SITES   = 2'd0,
        CFG_METRIC_MODE = 2'd1,
        CFG_EMPTY_LABEL = 2'd2
    } nsl_cfg_idx_t;

    typedef struct packed
    {
        nsl_cmd_t             cmd;
        logic [IDX_W-1:0]     site_index;
        logic [XY_W-1:0]      site_x;
        logic [XY_W-1:0]      site_y;
        logic [LABEL_W-1:0]   site_label;
        logic [XY_W-1:0]      query_x;
        logic [XY_W-1:0]      query_y;
    } nsl_item_t;

    typedef struct packed
    {
        logic                 found;
        logic [DW-1:0]        distance;
        logic [SLOT_W-1:0]    index;
        logic [LABEL_W-1:0]   label;
    } nsl_best_t;

    typedef struct packed
    {
        logic                 valid;
        nsl_item_t            item;
        nsl_best_t            best;
    } nsl_stage_t;

    typedef struct packed
    {
        logic [LABEL_W-1:0]   label;
        logic [IDX_W-1:0]     nearest_index;
        logic [DIST_W-1:0]    best_distance;
        logic                 no_sites;
    } nsl_result_t;

endpackage

/* design/nearest_site_labeler.sv */
// ----------------------------------------------------------------------------
// nearest_site_labeler
// Voronoi labeling of map positions with a systolic chain of site cells.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    cmd, site_index, site_x, site_y,
//                                    site_label, query_x, query_y
//   output    out_valid / out_ready  label, nearest_index, best_distance,
//                                    no_sites
//   config    cfg_we                 cfg_index, cfg_data
//
// One item, load or query, enters per cycle while in_ready is high and gives
// one result. Each site cell has a distance stage and a compare stage, and
// the output register adds one.
// Reset clears the valid bits and the configuration registers; site contents
// are undefined until loaded.
// When the output skid entry is full the whole chain holds and in_ready is low.
// ----------------------------------------------------------------------------
module nearest_site_labeler
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            cmd,
    input  logic [nsl_pkg::IDX_W-1:0]       site_index,
    input  logic [nsl_pkg::XY_W-1:0]        site_x,
    input  logic [nsl_pkg::XY_W-1:0]        site_y,
    input  logic [nsl_pkg::LABEL_W-1:0]     site_label,
    input  logic [nsl_pkg::XY_W-1:0]        query_x,
    input  logic [nsl_pkg::XY_W-1:0]        query_y,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [nsl_pkg::LABEL_W-1:0]     label,
    output logic [nsl_pkg::IDX_W-1:0]       nearest_index,
    output logic [nsl_pkg::DIST_W-1:0]      best_distance,
    output logic                            no_sites,

    input  logic                            cfg_we,
    input  logic [nsl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nsl_pkg::CFG_W-1:0]       cfg_data
);
    import nsl_pkg::*;

    logic [NUM_W-1:0]    num_sites_reg;
    nsl_metric_t         metric_mode_reg;
    logic [LABEL_W-1:0]  empty_label_reg;
    logic [ACT_W-1:0]    active;

    nsl_stage_t          chain [0:MAX_SITES];
    nsl_stage_t          last;
    nsl_result_t         result;
    nsl_result_t         out_data;
    logic                en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_sites_reg   <= '0;
            metric_mode_reg <= METRIC_EUCLID;
            empty_label_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (nsl_cfg_idx_t'(cfg_index))
                CFG_NUM_SITES:   num_sites_reg   <= cfg_data[NUM_W-1:0];
                CFG_METRIC_MODE: metric_mode_reg <= nsl_metric_t'(cfg_data[0]);
                CFG_EMPTY_LABEL: empty_label_reg <= cfg_data[LABEL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (ACT_W'(num_sites_reg) > ACT_W'(MAX_SITES))
        begin
            active = ACT_W'(MAX_SITES);
        end
        else
        begin
            active = ACT_W'(num_sites_reg);
        end
    end

    assign in_ready = en;

    always_comb
    begin
        chain[0].valid           = in_valid;
        chain[0].item.cmd        = nsl_cmd_t'(cmd);
        chain[0].item.site_index = site_index;
        chain[0].item.site_x     = site_x;
        chain[0].item.site_y     = site_y;
        chain[0].item.site_label = site_label;
        chain[0].item.query_x    = query_x;
        chain[0].item.query_y    = query_y;
        chain[0].best            = '0;
    end

    for (genvar i = 0; i < MAX_SITES; i++)
    begin : g_cell
        nsl_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (en),
            .cell_idx    (SLOT_W'(i)),
            .active      (active),
            .metric_mode (metric_mode_reg),
            .stage_in    (chain[i]),
            .stage_out   (chain[i+1])
        );
    end

    assign last = chain[MAX_SITES];

    always_comb
    begin
        result.label         = last.item.site_label;
        result.nearest_index = last.item.site_index;
        result.best_distance = '0;
        result.no_sites      = 1'b0;
        case (last.item.cmd)
            CMD_QUERY:
            begin
                if (last.best.found)
                begin
                    result.label         = last.best.label;
                    result.nearest_index = IDX_W'(last.best.index);
                    if (last.best.distance > DIST_MAX)
                    begin
                        result.best_distance = DIST_W'(DIST_MAX);
                    end
                    else
                    begin
                        result.best_distance = DIST_W'(last.best.distance);
                    end
                end
                else
                begin
                    result.label         = empty_label_reg;
                    result.nearest_index = '0;
                    result.no_sites      = 1'b1;
                end
            end
            CMD_LOAD:
            begin
                result.label         = last.item.site_label;
                result.nearest_index = last.item.site_index;
            end
            default:
            begin
                result.label         = last.item.site_label;
                result.nearest_index = last.item.site_index;
            end
        endcase
    end

    nsl_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (last.valid),
        .in_data   (result),
        .in_ready  (en),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_ready (out_ready)
    );

    assign label         = out_data.label;
    assign nearest_index = out_data.nearest_index;
    assign best_distance = out_data.best_distance;
    assign no_sites      = out_data.no_sites;

endmodule

/* design/nsl_cell.sv */
// ----------------------------------------------------------------------------
// nsl_cell
// One site of the systolic chain: holds the site, computes the distance from
// the passing query in a first stage and merges it into the running best in
// a second stage. A load whose site_index matches this cell updates the site.
// ----------------------------------------------------------------------------
module nsl_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [nsl_pkg::SLOT_W-1:0]    cell_idx,
    input  logic [nsl_pkg::ACT_W-1:0]     active,
    input  nsl_pkg::nsl_metric_t          metric_mode,
    input  nsl_pkg::nsl_stage_t           stage_in,
    output nsl_pkg::nsl_stage_t           stage_out
);
    import nsl_pkg::*;

    logic [COORD_BITS-1:0]  sx_reg;
    logic [COORD_BITS-1:0]  sy_reg;
    logic [LABEL_W-1:0]     slab_reg;

    logic                   a_valid_reg;
    nsl_item_t              a_item_reg;
    nsl_best_t              a_best_reg;
    logic [DW-1:0]          a_dist_reg;
    logic [LABEL_W-1:0]     a_lab_reg;
    logic [DW-1:0]          a_dist_next;

    logic                   b_valid_reg;
    nsl_item_t              b_item_reg;
    nsl_best_t              b_best_reg;
    nsl_best_t              b_best_next;

    logic                   load_hit;
    logic [COORD_BITS-1:0]  qx;
    logic [COORD_BITS-1:0]  qy;
    logic [COORD_BITS-1:0]  dx;
    logic [COORD_BITS-1:0]  dy;
    logic [2*COORD_BITS-1:0] sqx;
    logic [2*COORD_BITS-1:0] sqy;
    logic                   in_use;

    assign load_hit = en && stage_in.valid && (stage_in.item.cmd == CMD_LOAD)
                      && (CMP_W'(stage_in.item.site_index) == CMP_W'(cell_idx));

    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            sx_reg   <= stage_in.item.site_x[COORD_BITS-1:0];
            sy_reg   <= stage_in.item.site_y[COORD_BITS-1:0];
            slab_reg <= stage_in.item.site_label;
        end
    end

    always_comb
    begin
        qx  = stage_in.item.query_x[COORD_BITS-1:0];
        qy  = stage_in.item.query_y[COORD_BITS-1:0];
        dx  = (qx > sx_reg) ? (qx - sx_reg) : (sx_reg - qx);
        dy  = (qy > sy_reg) ? (qy - sy_reg) : (sy_reg - qy);
        sqx = dx * dx;
        sqy = dy * dy;
        case (metric_mode)
            METRIC_MANHATTAN: a_dist_next = DW'(dx) + DW'(dy);
            METRIC_EUCLID:    a_dist_next = DW'(sqx) + DW'(sqy);
            default:          a_dist_next = DW'(sqx) + DW'(sqy);
        endcase
    end

    always_comb
    begin
        in_use      = ACT_W'(cell_idx) < active;
        b_best_next = a_best_reg;
        if (in_use && (!a_best_reg.found || (a_dist_reg < a_best_reg.distance)))
        begin
            b_best_next.found    = 1'b1;
            b_best_next.distance = a_dist_reg;
            b_best_next.index    = cell_idx;
            b_best_next.label    = a_lab_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= stage_in.valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_item_reg <= stage_in.item;
            a_best_reg <= stage_in.best;
            a_dist_reg <= a_dist_next;
            a_lab_reg  <= slab_reg;
            b_item_reg <= a_item_reg;
            b_best_reg <= b_best_next;
        end
    end

    assign stage_out.valid = b_valid_reg;
    assign stage_out.item  = b_item_reg;
    assign stage_out.best  = b_best_reg;

endmodule

/* design/nsl_out_buf.sv */
// ----------------------------------------------------------------------------
// nsl_out_buf
// Output register with a skid entry, so the chain keeps moving while one
// result waits for the consumer.
// ----------------------------------------------------------------------------
module nsl_out_buf
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  nsl_pkg::nsl_result_t   in_data,
    output logic                   in_ready,
    output logic                   out_valid,
    output nsl_pkg::nsl_result_t   out_data,
    input  logic                   out_ready
);
    import nsl_pkg::*;

    logic         main_valid_reg;
    logic         main_valid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    nsl_result_t  main_reg;
    nsl_result_t  main_next;
    nsl_result_t  skid_reg;
    nsl_result_t  skid_next;
    logic         push;
    logic         pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign pop       = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

/* design/nsl_checker.sv */
// ----------------------------------------------------------------------------
// nsl_checker
// Port level checks for the nearest site labeler, bound to the top level.
// ----------------------------------------------------------------------------
module nsl_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [nsl_pkg::LABEL_W-1:0]     label,
    input  logic [nsl_pkg::IDX_W-1:0]       nearest_index,
    input  logic [nsl_pkg::DIST_W-1:0]      best_distance,
    input  logic                            no_sites
);
    import nsl_pkg::*;

    // A stalled result must stay offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(label) && $stable(nearest_index)
                                    && $stable(best_distance) && $stable(no_sites))
        else $error("output payload changed while stalled");

    // Backpressure on the input only comes from a waiting result.
    a_ready_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    a_ready_until_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && !(out_valid && out_ready) |=> !in_ready)
        else $error("input ready returned without an output transfer");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_sites |-> (nearest_index == '0) && (best_distance == '0))
        else $error("empty result carries an index or distance");

endmodule

bind nearest_site_labeler nsl_checker u_nsl_checker (.*);
